// File: design/mpbf_pkg.sv
// Shared types and codes for the multi-pipe byte FIFO.
// Used by mpbf_ctrl, mpbf_dp and multi_pipe_byte_fifo; depends on nothing.
package mpbf_pkg;

  localparam int FUNC_W   = 3;
  localparam int STATUS_W = 3;
  localparam int PID_W    = 4;
  localparam int BYTE_W   = 8;

  typedef enum logic [FUNC_W-1:0] {
    FN_ALLOC       = 3'd0,
    FN_WRITE       = 3'd1,
    FN_READ        = 3'd2,
    FN_CLOSE_READ  = 3'd3,
    FN_CLOSE_WRITE = 3'd4,
    FN_POLL        = 3'd5
  } func_t;

  typedef enum logic [STATUS_W-1:0] {
    STS_OK     = 3'd0,
    STS_EOF    = 3'd1,
    STS_BLOCK  = 3'd2,
    STS_BADEND = 3'd3,
    STS_EPIPE  = 3'd4,
    STS_NOFREE = 3'd5
  } status_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;   // latch the accepted request
    logic exec;      // apply the operation to the pipe table and ring
    logic load_out;  // fill the output register
  } dp_cmd_t;

endpackage

// File: design/mpbf_ctrl.sv
// Sequencing state machine for the multi-pipe byte FIFO.
// Depends on mpbf_pkg; drives the command struct of mpbf_dp.
module mpbf_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output mpbf_pkg::dp_cmd_t cmd
);
  import mpbf_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EXEC = 3'b010,
    S_LOAD = 3'b100
  } state_t;

  state_t state, state_next;
  logic   out_valid_next;
  logic   out_free;

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;

  always_comb begin
    state_next   = state;
    cmd.capture  = 1'b0;
    cmd.exec     = 1'b0;
    cmd.load_out = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec   = 1'b1;
        state_next = S_LOAD;
      end
      S_LOAD: begin
        // hold until the output register is free
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_next = out_valid;
    if (cmd.load_out) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

// File: design/mpbf_dp.sv
// Datapath of the multi-pipe byte FIFO: pipe table, ring memory, output register.
// Depends on mpbf_pkg; sequenced by mpbf_ctrl through dp_cmd_t.
module mpbf_dp #(
  parameter int RING_BYTES = 4096,
  parameter int PIPE_COUNT = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  mpbf_pkg::dp_cmd_t               cmd,
  input  logic [mpbf_pkg::FUNC_W-1:0]     func,
  input  logic [mpbf_pkg::PID_W-1:0]      pipe_id,
  input  logic [mpbf_pkg::BYTE_W-1:0]     data_in,
  output logic [mpbf_pkg::STATUS_W-1:0]   status,
  output logic [mpbf_pkg::BYTE_W-1:0]     data_out,
  output logic [mpbf_pkg::PID_W-1:0]      pipe_out,
  output logic                            read_ready,
  output logic                            write_ready
);
  import mpbf_pkg::*;

  localparam int IW        = $clog2(RING_BYTES);
  localparam int FW        = $clog2(RING_BYTES + 1);
  localparam int PW        = (PIPE_COUNT > 1) ? $clog2(PIPE_COUNT) : 1;
  // one spare bit so that PIPE_COUNT itself fits in the compare
  localparam int IDW       = ((PW > PID_W) ? PW : PID_W) + 1;
  localparam int MEM_DEPTH = PIPE_COUNT << IW;

  localparam logic [IW-1:0]  LAST_IDX  = IW'(RING_BYTES - 1);
  localparam logic [FW-1:0]  FULL_FILL = FW'(RING_BYTES);
  localparam logic [IDW-1:0] PIPE_LIM  = IDW'(PIPE_COUNT);

  // pipe table
  logic [IW-1:0] head      [PIPE_COUNT];
  logic [IW-1:0] tail      [PIPE_COUNT];
  logic [FW-1:0] fill      [PIPE_COUNT];
  logic          reader_on [PIPE_COUNT];
  logic          writer_on [PIPE_COUNT];
  logic          in_use    [PIPE_COUNT];

  logic [BYTE_W-1:0] ring [0:MEM_DEPTH-1];

  // latched request
  logic [FUNC_W-1:0] func_q;
  logic [IDW-1:0]    pid_q;
  logic [BYTE_W-1:0] din_q;

  // result of the execute step
  logic [STATUS_W-1:0] status_q;
  logic [IDW-1:0]      pout_q;
  logic                report_q;
  logic                read_ok_q;
  logic [BYTE_W-1:0]   rd_data;

  logic [PW-1:0] pidx;
  logic          pid_valid;
  logic [PW-1:0] grant;
  logic          any_free;

  logic [STATUS_W-1:0] ex_status;
  logic [IDW-1:0]      ex_pout;
  logic                ex_report;
  logic                do_alloc, do_write, do_read, do_close_rd, do_close_wr;

  logic [PW-1:0] ridx;
  logic          rpipe_ok;

  function automatic logic [IW-1:0] advance(input logic [IW-1:0] pos);
    return (pos == LAST_IDX) ? '0 : pos + 1'b1;
  endfunction

  assign pidx      = pid_q[PW-1:0];
  assign pid_valid = (pid_q < PIPE_LIM) && in_use[pidx];

  // lowest free pipe
  always_comb begin
    grant    = '0;
    any_free = 1'b0;
    for (int i = PIPE_COUNT - 1; i >= 0; i--) begin
      if (!in_use[i]) begin
        grant    = PW'(i);
        any_free = 1'b1;
      end
    end
  end

  always_comb begin
    ex_status   = STS_OK;
    ex_pout     = pid_q;
    ex_report   = 1'b1;
    do_alloc    = 1'b0;
    do_write    = 1'b0;
    do_read     = 1'b0;
    do_close_rd = 1'b0;
    do_close_wr = 1'b0;
    case (func_q)
      FN_ALLOC: begin
        if (any_free) begin
          ex_pout  = IDW'(grant);
          do_alloc = 1'b1;
        end else begin
          ex_status = STS_NOFREE;
          ex_report = 1'b0;
        end
      end
      FN_WRITE: begin
        if (!pid_valid || !writer_on[pidx]) begin
          ex_status = STS_BADEND;
        end else if (!reader_on[pidx]) begin
          ex_status = STS_EPIPE;
        end else if (fill[pidx] >= FULL_FILL) begin
          ex_status = STS_BLOCK;
        end else begin
          do_write = 1'b1;
        end
      end
      FN_READ: begin
        if (!pid_valid || !reader_on[pidx]) begin
          ex_status = STS_BADEND;
        end else if (fill[pidx] == '0) begin
          ex_status = writer_on[pidx] ? STS_BLOCK : STS_EOF;
        end else begin
          do_read = 1'b1;
        end
      end
      FN_CLOSE_READ: begin
        if (!pid_valid || !reader_on[pidx]) begin
          ex_status = STS_BADEND;
        end else begin
          do_close_rd = 1'b1;
        end
      end
      FN_CLOSE_WRITE: begin
        if (!pid_valid || !writer_on[pidx]) begin
          ex_status = STS_BADEND;
        end else begin
          do_close_wr = 1'b1;
        end
      end
      FN_POLL: ex_status = STS_OK;
      default: ex_status = STS_BADEND;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      func_q <= func;
      pid_q  <= IDW'(pipe_id);
      din_q  <= data_in;
    end
    if (cmd.exec) begin
      status_q  <= ex_status;
      pout_q    <= ex_pout;
      report_q  <= ex_report;
      read_ok_q <= do_read;
    end
  end

  // pipe table update
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < PIPE_COUNT; i++) begin
        head[i]      <= '0;
        tail[i]      <= '0;
        fill[i]      <= '0;
        reader_on[i] <= 1'b0;
        writer_on[i] <= 1'b0;
        in_use[i]    <= 1'b0;
      end
    end else if (cmd.exec) begin
      if (do_alloc) begin
        head[grant]      <= '0;
        tail[grant]      <= '0;
        fill[grant]      <= '0;
        reader_on[grant] <= 1'b1;
        writer_on[grant] <= 1'b1;
        in_use[grant]    <= 1'b1;
      end
      if (do_write) begin
        tail[pidx] <= advance(tail[pidx]);
        fill[pidx] <= fill[pidx] + 1'b1;
      end
      if (do_read) begin
        head[pidx] <= advance(head[pidx]);
        fill[pidx] <= fill[pidx] - 1'b1;
      end
      // free the pipe once both ends are closed
      if (do_close_rd) begin
        reader_on[pidx] <= 1'b0;
        if (!writer_on[pidx]) begin
          in_use[pidx] <= 1'b0;
        end
      end
      if (do_close_wr) begin
        writer_on[pidx] <= 1'b0;
        if (!reader_on[pidx]) begin
          in_use[pidx] <= 1'b0;
        end
      end
    end
  end

  // ring memory: at most one write per request; the registered read runs on every request
  always_ff @(posedge clk) begin
    if (cmd.exec && do_write) begin
      ring[{pidx, tail[pidx]}] <= din_q;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      rd_data <= ring[{pidx, head[pidx]}];
    end
  end

  // readiness of the reported pipe, taken from the updated table
  assign ridx     = pout_q[PW-1:0];
  assign rpipe_ok = report_q && (pout_q < PIPE_LIM) && in_use[ridx];

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      status      <= status_q;
      data_out    <= read_ok_q ? rd_data : '0;
      pipe_out    <= pout_q[PID_W-1:0];
      read_ready  <= rpipe_ok && reader_on[ridx] &&
                     ((fill[ridx] != '0) || !writer_on[ridx]);
      write_ready <= rpipe_ok && writer_on[ridx] &&
                     (!reader_on[ridx] || (fill[ridx] < FULL_FILL));
    end
  end

endmodule

// File: design/multi_pipe_byte_fifo.sv
// Multi-pipe byte FIFO: a bank of circular byte pipes driven one request at a time.
// The result is valid after the execute and load steps that follow acceptance; the load
// step waits while the output register still holds an untaken result. A new request is
// taken only from the idle state; a result may wait in the output register while the next runs.
// Reset (rst, synchronous): all pipes free and empty; ring contents stay undefined.
// Depends on mpbf_pkg, mpbf_ctrl and mpbf_dp.
module multi_pipe_byte_fifo #(
  parameter int RING_BYTES = 4096,
  parameter int PIPE_COUNT = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [mpbf_pkg::FUNC_W-1:0]   func,
  input  logic [mpbf_pkg::PID_W-1:0]    pipe_id,
  input  logic [mpbf_pkg::BYTE_W-1:0]   data_in,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [mpbf_pkg::STATUS_W-1:0] status,
  output logic [mpbf_pkg::BYTE_W-1:0]   data_out,
  output logic [mpbf_pkg::PID_W-1:0]    pipe_out,
  output logic                          read_ready,
  output logic                          write_ready
);
  import mpbf_pkg::*;

  dp_cmd_t cmd;

  mpbf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  mpbf_dp #(
    .RING_BYTES (RING_BYTES),
    .PIPE_COUNT (PIPE_COUNT)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .func        (func),
    .pipe_id     (pipe_id),
    .data_in     (data_in),
    .status      (status),
    .data_out    (data_out),
    .pipe_out    (pipe_out),
    .read_ready  (read_ready),
    .write_ready (write_ready)
  );

endmodule
